@@ hw/rtl/ctl_pkg.sv @@
// Shared types, sizes and codes for the countdown timer list.
`timescale 1ns / 1ps
`default_nettype none
package ctl_pkg;

	// sizes
	localparam int SLOTS     = 16;
	localparam int TIME_BITS = 24;
	localparam int TYPE_BITS = 8;
	localparam int STEP_W    = 16;
	localparam int IDX_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W     = $clog2(SLOTS + 1);
	localparam int CMP_W     = (TIME_BITS > STEP_W) ? TIME_BITS : STEP_W;
	localparam int CFG_W     = (TIME_BITS > STEP_W) ? TIME_BITS : STEP_W;
	localparam int ENT_W     = TIME_BITS + TYPE_BITS;

	// register reset values
	localparam logic [TIME_BITS-1:0] MIN_DURATION_RST = TIME_BITS'(250);
	localparam logic [STEP_W-1:0]    TICK_STEP_RST    = STEP_W'(250);

	// register indexes
	localparam logic REG_MIN_DURATION = 1'b0;
	localparam logic REG_TICK_STEP    = 1'b1;

	// commands
	localparam logic CMD_ADD  = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	// add status codes
	localparam logic [1:0] ST_ADDED = 2'd0;
	localparam logic [1:0] ST_SHORT = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_NONE  = 2'd3;

	typedef struct packed {
		logic                 cmd;
		logic [TIME_BITS-1:0] duration_ms;
		logic [TYPE_BITS-1:0] timer_type;
	} req_t;

	typedef struct packed {
		logic [1:0]           add_status;
		logic                 fired_valid;
		logic [TYPE_BITS-1:0] fired_type;
		logic [CNT_W-1:0]     active_count;
		logic                 last;
	} rsp_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SWEEP,
		S_DRAIN_RD,
		S_DRAIN_OUT
	} state_t;

endpackage
`default_nettype wire

@@ hw/rtl/ctl_ram.sv @@
// Generic single-port-write, single-port-read synchronous RAM.
`timescale 1ns / 1ps
`default_nettype none
module ctl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read, data held between reads
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/ctl_out.sv @@
// Output register stage for result requests.
`timescale 1ns / 1ps
`default_nettype none
module ctl_out (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire ctl_pkg::rsp_t push_data,
	output logic               can_push,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output ctl_pkg::rsp_t      rsp
);
	import ctl_pkg::*;

	logic valid_q;
	rsp_t data_q;

	// room when empty or when the held result leaves this cycle
	assign can_push  = !valid_q || !rsp_stall;
	assign rsp_valid = valid_q;
	assign rsp       = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push) begin
			valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			data_q <= push_data;
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/countdown_timer_list_core.sv @@
// Top level of the countdown timer list: sequencer around the entry and fired memories.
//
// Usage:
//   Requests enter on req/req_valid/req_stall; results leave on rsp/rsp_valid/
//   rsp_stall. A transfer happens at a clock edge with valid high and stall low.
//   Configuration is written through cfg_we/cfg_index/cfg_wdata while idle:
//   index 0 is the minimum duration, index 1 the tick step.
//   An add request gives one result, registered in the cycle after acceptance.
//   A tick sweeps the entry memory once, one entry per cycle, compacting the
//   survivors in place and parking expired tags in a fired memory. Expired
//   tags then leave one at a time, each read from the fired memory and then
//   handed to the output register, in list order, last set on the final one;
//   a tick with no expiry gives a single empty result.
//   One request is handled at a time; the next is taken once the previous
//   one has handed its final result to the output register and that
//   register is empty or its held result leaves in the same cycle.
//   While the receiver stalls, the output register holds its result and the
//   sequencer waits.
//   Reset empties the list and sets both registers to 250; the memories are
//   not cleared, only entries below the count are ever read.
`timescale 1ns / 1ps
`default_nettype none
module countdown_timer_list_core (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  req_valid,
	output logic                       req_stall,
	input  wire ctl_pkg::req_t         req,
	output logic                       rsp_valid,
	input  wire logic                  rsp_stall,
	output ctl_pkg::rsp_t              rsp,
	input  wire logic                  cfg_we,
	input  wire logic                  cfg_index,
	input  wire logic [ctl_pkg::CFG_W-1:0] cfg_wdata
);
	import ctl_pkg::*;

	// configuration registers
	logic [TIME_BITS-1:0] min_duration_q;
	logic [STEP_W-1:0]    tick_step_q;

	// control state
	state_t           state_q, state_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [CNT_W-1:0] rd_idx_q, rd_idx_d;
	logic [CNT_W-1:0] keep_q, keep_d;
	logic [CNT_W-1:0] nfired_q, nfired_d;
	logic [CNT_W-1:0] drn_q, drn_d;
	logic             vld_s1;

	// memory ports
	logic                 ent_we, ent_re;
	logic [IDX_W-1:0]     ent_waddr;
	logic [ENT_W-1:0]     ent_wdata, ent_rdata;
	logic                 fir_we, fir_re;
	logic [TYPE_BITS-1:0] fir_rdata;

	// output stage
	logic can_push, push;
	rsp_t push_data;

	// sweep datapath
	logic                 issue, expired, sweep_done, accept, fire_last;
	logic [TIME_BITS-1:0] rem_s1;
	logic [TYPE_BITS-1:0] typ_s1;
	logic [CMP_W-1:0]     rem_ext, step_ext, rem_dec;

	assign rem_s1   = ent_rdata[ENT_W-1:TYPE_BITS];
	assign typ_s1   = ent_rdata[TYPE_BITS-1:0];
	assign rem_ext  = CMP_W'(rem_s1);
	assign step_ext = CMP_W'(tick_step_q);
	assign expired  = rem_ext <= step_ext;
	assign rem_dec  = rem_ext - step_ext;

	assign issue      = (state_q == S_SWEEP) && (rd_idx_q < count_q);
	assign sweep_done = (state_q == S_SWEEP) && !issue && !vld_s1;
	assign accept     = req_valid && !req_stall;
	assign req_stall  = !((state_q == S_IDLE) && can_push);
	assign fire_last  = (drn_q + CNT_W'(1)) == nfired_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_duration_q <= MIN_DURATION_RST;
			tick_step_q    <= TICK_STEP_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MIN_DURATION: min_duration_q <= cfg_wdata[TIME_BITS-1:0];
				REG_TICK_STEP:    tick_step_q    <= cfg_wdata[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	// next state, counters and memory/result controls
	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		rd_idx_d  = rd_idx_q;
		keep_d    = keep_q;
		nfired_d  = nfired_q;
		drn_d     = drn_q;
		ent_we    = 1'b0;
		ent_waddr = keep_q[IDX_W-1:0];
		ent_wdata = {rem_dec[TIME_BITS-1:0], typ_s1};
		fir_we    = 1'b0;
		fir_re    = 1'b0;
		push      = 1'b0;
		push_data = '{add_status: ST_NONE, fired_valid: 1'b0,
			fired_type: '0, active_count: count_q, last: 1'b1};

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (req.cmd == CMD_TICK) begin
						state_d  = S_SWEEP;
						rd_idx_d = '0;
						keep_d   = '0;
						nfired_d = '0;
					end else begin
						push = 1'b1;
						if (req.duration_ms < min_duration_q) begin
							push_data.add_status = ST_SHORT;
						end else if (count_q >= CNT_W'(SLOTS)) begin
							push_data.add_status = ST_FULL;
						end else begin
							ent_we    = 1'b1;
							ent_waddr = count_q[IDX_W-1:0];
							ent_wdata = {req.duration_ms, req.timer_type};
							count_d   = count_q + CNT_W'(1);
							push_data.add_status   = ST_ADDED;
							push_data.active_count = count_q + CNT_W'(1);
						end
					end
				end
			end
			S_SWEEP: begin
				if (issue) begin
					rd_idx_d = rd_idx_q + CNT_W'(1);
				end
				// entry read last cycle: keep and lower, or park its tag
				if (vld_s1) begin
					if (expired) begin
						fir_we   = 1'b1;
						nfired_d = nfired_q + CNT_W'(1);
					end else begin
						ent_we = 1'b1;
						keep_d = keep_q + CNT_W'(1);
					end
				end
				if (sweep_done) begin
					count_d = keep_q;
					if (nfired_q != '0) begin
						state_d = S_DRAIN_RD;
						drn_d   = '0;
					end else if (can_push) begin
						push = 1'b1;
						push_data.active_count = keep_q;
						state_d = S_IDLE;
					end
				end
			end
			S_DRAIN_RD: begin
				fir_re  = 1'b1;
				state_d = S_DRAIN_OUT;
			end
			S_DRAIN_OUT: begin
				if (can_push) begin
					push = 1'b1;
					push_data.fired_valid = 1'b1;
					push_data.fired_type  = fir_rdata;
					push_data.last        = fire_last;
					drn_d   = drn_q + CNT_W'(1);
					state_d = fire_last ? S_IDLE : S_DRAIN_RD;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			rd_idx_q <= '0;
			keep_q   <= '0;
			nfired_q <= '0;
			drn_q    <= '0;
			vld_s1   <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			rd_idx_q <= rd_idx_d;
			keep_q   <= keep_d;
			nfired_q <= nfired_d;
			drn_q    <= drn_d;
			vld_s1   <= issue;
		end
	end

	assign ent_re = issue;

	// remaining time and type per list entry
	ctl_ram #(
		.WIDTH (ENT_W),
		.DEPTH (SLOTS)
	) u_ent_ram (
		.clk   (clk),
		.we    (ent_we),
		.waddr (ent_waddr),
		.wdata (ent_wdata),
		.re    (ent_re),
		.raddr (rd_idx_q[IDX_W-1:0]),
		.rdata (ent_rdata)
	);

	// tags of timers expired on the current tick
	ctl_ram #(
		.WIDTH (TYPE_BITS),
		.DEPTH (SLOTS)
	) u_fir_ram (
		.clk   (clk),
		.we    (fir_we),
		.waddr (nfired_q[IDX_W-1:0]),
		.wdata (typ_s1),
		.re    (fir_re),
		.raddr (drn_q[IDX_W-1:0]),
		.rdata (fir_rdata)
	);

	ctl_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.can_push  (can_push),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule
`default_nettype wire

@@ tb/sv/countdown_timer_list_core_tb.sv @@
// Testbench for the countdown timer list core: shadow timer list, result checker, traffic.
`timescale 1ns / 1ps
module countdown_timer_list_core_tb;
	import ctl_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int REPORT_LIMIT   = 10;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 req_valid = 1'b0;
	logic                 req_stall;
	req_t                 req       = '0;
	logic                 rsp_valid;
	logic                 rsp_stall = 1'b0;
	rsp_t                 rsp;
	logic                 cfg_we    = 1'b0;
	logic                 cfg_index = REG_MIN_DURATION;
	logic [CFG_W-1:0]     cfg_wdata = '0;

	// shadow copy of the timer list and its registers
	logic [TIME_BITS:0]   shadow_left [SLOTS];
	logic [TYPE_BITS-1:0] shadow_tag  [SLOTS];
	int                   shadow_count   = 0;
	logic [TIME_BITS-1:0] shadow_min_dur = MIN_DURATION_RST;
	logic [STEP_W-1:0]    shadow_step    = TICK_STEP_RST;

	rsp_t due_results [$];
	int   fault_count   = 0;
	int   send_idle_pct = 13;
	int   recv_idle_pct = 54;
	int   hold_off_left = 0;
	int   quiet_cycles  = 0;

	countdown_timer_list_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// append one expected result at the tail of the pending list
	task automatic queue_result(input rsp_t r);
		due_results.insert(due_results.size(), r);
	endtask

	// apply one accepted request to the shadow list and queue its results
	task automatic predict_timer_request(input req_t r);
		logic [TYPE_BITS-1:0] fired_tags [SLOTS];
		int   n_fired;
		int   keep;
		rsp_t res;
		res = '0;
		res.last = 1'b1;
		if (r.cmd == CMD_ADD) begin
			if (r.duration_ms < shadow_min_dur) begin
				res.add_status = ST_SHORT;
			end else if (shadow_count >= SLOTS) begin
				res.add_status = ST_FULL;
			end else begin
				shadow_left[shadow_count] = {1'b0, r.duration_ms};
				shadow_tag[shadow_count]  = r.timer_type;
				shadow_count++;
				res.add_status = ST_ADDED;
			end
			res.active_count = CNT_W'(shadow_count);
			queue_result(res);
		end else begin
			n_fired = 0;
			keep    = 0;
			// every timer is lowered; expired ones leave, survivors close up
			for (int i = 0; i < shadow_count; i++) begin
				if (shadow_left[i] <= shadow_step) begin
					fired_tags[n_fired] = shadow_tag[i];
					n_fired++;
				end else begin
					shadow_left[keep] = shadow_left[i] - shadow_step;
					shadow_tag[keep]  = shadow_tag[i];
					keep++;
				end
			end
			shadow_count     = keep;
			res.add_status   = ST_NONE;
			res.active_count = CNT_W'(shadow_count);
			if (n_fired == 0) begin
				queue_result(res);
			end else begin
				for (int i = 0; i < n_fired; i++) begin
					res.fired_valid = 1'b1;
					res.fired_type  = fired_tags[i];
					res.last        = (i == n_fired - 1);
					queue_result(res);
				end
			end
		end
	endtask

	// offer one request, optionally after a gap, and hold it until taken
	task automatic send_request(input req_t r);
		if ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		req       <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		predict_timer_request(r);
	endtask

	task automatic send_timer_op(input logic cmd, input int dur, input int tag);
		req_t r;
		r.cmd         = cmd;
		r.duration_ms = TIME_BITS'(dur);
		r.timer_type  = TYPE_BITS'(tag);
		send_request(r);
	endtask

	task automatic wait_until_idle();
		req_valid <= 1'b0;
		while (due_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_timer_config(input logic [TIME_BITS-1:0] min_dur,
			input logic [STEP_W-1:0] step);
		wait_until_idle();
		cfg_we    <= 1'b1;
		cfg_index <= REG_MIN_DURATION;
		cfg_wdata <= CFG_W'(min_dur);
		@(posedge clk);
		cfg_index <= REG_TICK_STEP;
		cfg_wdata <= CFG_W'(step);
		@(posedge clk);
		cfg_we <= 1'b0;
		shadow_min_dur = min_dur;
		shadow_step    = step;
	endtask

	// durations cluster around the step so timers live a few ticks
	function automatic req_t random_timer_request();
		req_t        r;
		logic [63:0] d;
		int          pick;
		r.cmd        = ($urandom_range(99) < 55) ? CMD_ADD : CMD_TICK;
		r.timer_type = TYPE_BITS'($urandom);
		pick = $urandom_range(7);
		if (pick < 2 && shadow_min_dur != 0)
			d = $urandom_range(shadow_min_dur - 1);
		else if (pick == 2)
			d = shadow_min_dur + $urandom_range(3);
		else
			d = shadow_step * $urandom_range(6) + $urandom_range(shadow_step);
		if (d > 64'hFFFFFF)
			d = 64'hFFFFFF;
		r.duration_ms = TIME_BITS'(d);
		return r;
	endfunction

	// reset values of both registers, boundary of the minimum, first expiry
	task automatic test_reset_config_expiry();
		send_timer_op(CMD_ADD, 249, 8'h01);
		send_timer_op(CMD_ADD, 250, 8'hFF);
		send_timer_op(CMD_ADD, 24'hFFFFFF, 8'h00);
		send_timer_op(CMD_TICK, 24'hFFFFFF, 8'hFF);
		send_timer_op(CMD_TICK, 0, 0);
	endtask

	// fill the list, then short and full rejects, then multi-expiry ticks
	task automatic test_full_list();
		int i;
		set_timer_config(100, 16'hFFFF);
		i = 0;
		while (shadow_count < SLOTS) begin
			case (i % 3)
				0: send_timer_op(CMD_ADD, 100 + i, i * 17);
				1: send_timer_op(CMD_ADD, 65535, i * 17);
				default: send_timer_op(CMD_ADD, 65536 + i, i * 17);
			endcase
			i++;
		end
		send_timer_op(CMD_ADD, 99, 8'hFF);
		send_timer_op(CMD_ADD, 24'hFFFFFF, 8'h55);
		send_timer_op(CMD_TICK, 0, 0);
		send_timer_op(CMD_TICK, 0, 0);
	endtask

	// zero minimum and zero step: a zero timer still expires
	task automatic test_zero_step();
		set_timer_config(0, 0);
		send_timer_op(CMD_ADD, 0, 8'h3C);
		send_timer_op(CMD_TICK, 0, 0);
		send_timer_op(CMD_TICK, 0, 0);
	endtask

	task automatic test_random_traffic(input int n, input int s_pct, input int r_pct,
			input logic [TIME_BITS-1:0] min_dur, input logic [STEP_W-1:0] step);
		set_timer_config(min_dur, step);
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		repeat (n) send_request(random_timer_request());
	endtask

	// receiver holds off for a long stretch while requests keep coming
	task automatic test_output_backpressure(input int n);
		set_timer_config(TIME_BITS'($urandom_range(2000)), STEP_W'($urandom_range(1, 65535)));
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_off_left = 400;
		repeat (n) send_request(random_timer_request());
	endtask

	// receiver stall
	always @(posedge clk) begin
		if (hold_off_left > 0) begin
			hold_off_left--;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	function automatic string describe(input rsp_t r);
		return $sformatf("status %0d fired %0d type %02h count %0d last %0d",
			r.add_status, r.fired_valid, r.fired_type, r.active_count, r.last);
	endfunction

	// compare each result with the oldest pending one
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (due_results.size() == 0) begin
				fault_count++;
				if (fault_count <= REPORT_LIMIT)
					$display("result with nothing pending: %s", describe(rsp));
			end else begin
				want = due_results.pop_front();
				if (rsp.add_status !== want.add_status || rsp.fired_valid !== want.fired_valid
						|| rsp.fired_type !== want.fired_type
						|| rsp.active_count !== want.active_count
						|| rsp.last !== want.last) begin
					fault_count++;
					if (fault_count <= REPORT_LIMIT)
						$display("result mismatch at %0t: expected %s, got %s",
							$realtime, describe(want), describe(rsp));
				end
			end
		end
	end

	// watchdog on cycles with no transfer on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_config_expiry();
		test_full_list();
		test_zero_step();
		test_random_traffic(120, 13, 54, 100, 250);
		test_random_traffic(120, 54, 13, 0, 1);
		test_output_backpressure(40);
		test_random_traffic(70, 0, 0, TIME_BITS'($urandom_range(2000)),
			STEP_W'($urandom_range(1, 65535)));
		test_random_traffic(80, 0, 0, 0, 16'hFFFF);
		test_random_traffic(40, 0, 0, 24'hFFFFFF, 16'hFFFF);

		wait_until_idle();
		repeat (20) @(posedge clk);
		if (fault_count == 0 && due_results.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
